FILE: sv/crc16w_pkg.sv
// Package with the queue entry type, CRC constants and the byte fold function.
package crc16w_pkg;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
  localparam int          QUEUE_DEPTH   = 2;
  localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] data_word;
    logic        use_low_byte;
    logic        use_high_byte;
    logic        start_new;
  } word_entry_t;

  typedef struct packed {
    logic        valid;
    word_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {8'h00, b ^ crc[7:0]};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return {8'h00, crc[15:8]} ^ c;
  endfunction

endpackage

FILE: sv/crc16w_front.sv
// Front end: accepts input words and holds them in a short queue for the back end.
module crc16w_front
  import crc16w_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_data_word,
  input  logic          in_use_low_byte,
  input  logic          in_use_high_byte,
  input  logic          in_start_new,
  output queue_head_t   head,
  input  logic          pop,
  output queue_status_t status
);

  word_entry_t       mem_r [QUEUE_DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop_ok;
  word_entry_t       new_entry;

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop_ok   = pop && (count_r != '0);

  always_comb begin
    new_entry.data_word     = in_data_word;
    new_entry.use_low_byte  = in_use_low_byte;
    new_entry.use_high_byte = in_use_high_byte;
    new_entry.start_new     = in_start_new;
  end

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  assign head.valid   = (count_r != '0);
  assign head.entry   = mem_r[rd_ptr_r];
  assign status.push  = push;
  assign status.pop   = pop_ok;
  assign status.count = count_r;

endmodule

FILE: sv/crc16w_back.sv
// Back end: folds the enabled bytes into the running CRC and registers the result.
module crc16w_back
  import crc16w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_crc_value
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] out_crc_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] base_crc;
  logic [15:0] after_lo;

  assign pop = head.valid && (!out_valid_r || out_ready);

  always_comb begin
    base_crc = head.entry.start_new ? 16'h0000 : crc_r;
    after_lo = head.entry.use_low_byte ?
               fold_byte(base_crc, head.entry.data_word[7:0]) : base_crc;
    crc_nxt  = head.entry.use_high_byte ?
               fold_byte(after_lo, head.entry.data_word[15:8]) : after_lo;
    out_valid_nxt = pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_crc_r <= crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

FILE: sv/crc16_word_packed_bytes.sv
// Top level of the CRC-16 engine over byte-packed 16-bit words.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    data_word, use_low_byte, use_high_byte, start_new
//   out_     output     out_valid / out_ready  crc_value
//
// One word per cycle is sustained while out_ready stays high; the back end folds both bytes
// of a word combinationally, in the same cycle it pops the word. A word is first written
// into the queue, and its CRC is registered into the output register when the back end
// pops it. Reset clears the queue, the running CRC and the output valid flag. While
// the output stalls the input takes words until the two-entry queue is full.
module crc16_word_packed_bytes
  import crc16w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_data_word,
  input  logic        in_use_low_byte,
  input  logic        in_use_high_byte,
  input  logic        in_start_new,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_crc_value
);

  queue_head_t   head;
  queue_status_t status;
  logic          pop;

  crc16w_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_word     (in_data_word),
    .in_use_low_byte  (in_use_low_byte),
    .in_use_high_byte (in_use_high_byte),
    .in_start_new     (in_start_new),
    .head             (head),
    .pop              (pop),
    .status           (status)
  );

  crc16w_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_crc_value (out_crc_value)
  );

  a_count_track : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> status.count == $past(status.count) + QCNT_W'($past(status.push))
                             - QCNT_W'($past(status.pop)))
    else $error("queue count does not follow pushes and pops");

  a_full_has_head : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> head.valid)
    else $error("queue refuses words while empty");

  a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.entry.start_new && !head.entry.use_low_byte && !head.entry.use_high_byte)
    |=> (out_valid && out_crc_value == 16'h0000))
    else $error("start without enabled bytes did not report a cleared CRC");

  a_pop_fills_output : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped word produced no result");

endmodule
